/* rtl/core/pcp_pkg.sv */
// ----------------------------------------------------------------------------
// pcp_pkg: shared types and constants for the pump current protection unit
// Status and operation codes, register indexes, limit widths and the
// configuration and state records passed between modules.
// ----------------------------------------------------------------------------
package pcp_pkg;

    // pump status codes
    localparam logic [2:0] ST_OFF      = 3'd0;
    localparam logic [2:0] ST_ON       = 3'd1;
    localparam logic [2:0] ST_DRY      = 3'd2;
    localparam logic [2:0] ST_OVERLOAD = 3'd3;
    localparam logic [2:0] ST_FLOOD    = 3'd4;

    // operation codes
    localparam logic [1:0] FN_UPDATE = 2'd0;
    localparam logic [1:0] FN_START  = 2'd1;
    localparam logic [1:0] FN_STOP   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MIN_CURRENT  = 3'd0;
    localparam logic [2:0] REG_MAX_CURRENT  = 3'd1;
    localparam logic [2:0] REG_START_GRACE  = 3'd2;
    localparam logic [2:0] REG_DRY_SECONDS  = 3'd3;
    localparam logic [2:0] REG_MAX_RUN_HRS  = 3'd4;
    localparam logic [2:0] REG_OVL_HOLD     = 3'd5;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DRY_LIM_W   = 26;   // 65535 s in ms
    localparam int FLOOD_LIM_W = 30;   // 255 h in ms

    localparam logic [DRY_LIM_W-1:0]   MS_PER_SECOND = 26'd1000;
    localparam logic [FLOOD_LIM_W-1:0] MS_PER_HOUR   = 30'd3600000;

    // register reset values
    localparam logic [15:0] RST_MIN_CURRENT = 16'd500;
    localparam logic [15:0] RST_MAX_CURRENT = 16'd10000;
    localparam logic [15:0] RST_START_GRACE = 16'd3000;
    localparam logic [15:0] RST_OVL_HOLD    = 16'd500;
    localparam logic [DRY_LIM_W-1:0]   RST_DRY_LIM   = 26'd10000;
    localparam logic [FLOOD_LIM_W-1:0] RST_FLOOD_LIM = 30'd7200000;

    typedef struct packed {
        logic [15:0]             min_ma;
        logic [15:0]             max_ma;
        logic [15:0]             grace_ms;
        logic [15:0]             hold_ms;
        logic [DRY_LIM_W-1:0]    dry_lim;
        logic [FLOOD_LIM_W-1:0]  flood_lim;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic        was_running;
        logic        drive;
        logic        lock;
        logic        ovl_armed;
        logic        dry_armed;
        logic        fld_armed;
        logic [31:0] grace_stamp;
        logic [31:0] ovl_stamp;
        logic [31:0] dry_stamp;
        logic [31:0] fld_stamp;
    } t_state;

endpackage

/* rtl/core/pump_current_protection_unit.sv */
// ----------------------------------------------------------------------------
// pump_current_protection_unit: pump drive protection controller
// Takes update, start and stop items and returns the pump status for each.
// ----------------------------------------------------------------------------
// One item is accepted per clock while o_s_tready is high; its result appears
// in the output register on the next cycle. The rate is set by the single
// state update per item, done in the cycle the item is accepted. The input
// side stays ready while the output register is empty or being drained.
module pump_current_protection_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,    // now_ms[31:0], current_ma[47:32], web_command[48]
    input  logic [1:0]  i_s_tuser,    // func[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,    // pump_status[2:0], drive_on[3], in_grace[4], start_locked[5]
    input  logic        i_cfg_we,
    input  logic [pcp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pcp_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    pcp_pkg::t_cfg   cfg;
    pcp_pkg::t_state r_state;
    pcp_pkg::t_state n_state;
    logic            n_grace;
    logic            accept;
    logic            r_out_valid;
    logic [7:0]      r_out_data;

    pcp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pcp_step u_step (
        .i_state       (r_state),
        .i_cfg         (cfg),
        .i_func        (i_s_tuser),
        .i_now_ms      (i_s_tdata[31:0]),
        .i_current_ma  (i_s_tdata[47:32]),
        .i_web_command (i_s_tdata[48]),
        .o_state       (n_state),
        .o_in_grace    (n_grace)
    );

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.status      <= pcp_pkg::ST_OFF;
            r_state.was_running <= 1'b0;
            r_state.drive       <= 1'b0;
            r_state.lock        <= 1'b0;
            r_state.ovl_armed   <= 1'b1;
            r_state.dry_armed   <= 1'b1;
            r_state.fld_armed   <= 1'b1;
            r_state.grace_stamp <= '0;
            r_state.ovl_stamp   <= '0;
            r_state.dry_stamp   <= '0;
            r_state.fld_stamp   <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, n_state.lock, n_grace, n_state.drive, n_state.status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // drive is only energized while running normally
    a_drive_means_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.drive |-> r_state.status == pcp_pkg::ST_ON)
        else $error("drive on outside running status");

    // unlocked start reports running next
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tuser == pcp_pkg::FN_START && !r_state.lock)
        |=> (o_m_tvalid && o_m_tdata[2:0] == pcp_pkg::ST_ON && o_m_tdata[3]))
        else $error("start not reported as running");

    // lockout only comes from a web stop
    a_lock_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.lock && !(accept && i_s_tuser == pcp_pkg::FN_STOP && i_s_tdata[48]))
        |=> !r_state.lock)
        else $error("lockout set without web stop");

endmodule

/* rtl/core/pcp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pcp_cfg_regs: configuration register file
// Holds the thresholds and turns the second and hour settings into
// millisecond limits when they are written.
// ----------------------------------------------------------------------------
module pcp_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [pcp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output pcp_pkg::t_cfg                     o_cfg
);

    pcp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_ma    <= pcp_pkg::RST_MIN_CURRENT;
            r_cfg.max_ma    <= pcp_pkg::RST_MAX_CURRENT;
            r_cfg.grace_ms  <= pcp_pkg::RST_START_GRACE;
            r_cfg.hold_ms   <= pcp_pkg::RST_OVL_HOLD;
            r_cfg.dry_lim   <= pcp_pkg::RST_DRY_LIM;
            r_cfg.flood_lim <= pcp_pkg::RST_FLOOD_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pcp_pkg::REG_MIN_CURRENT: r_cfg.min_ma   <= i_cfg_wdata;
                pcp_pkg::REG_MAX_CURRENT: r_cfg.max_ma   <= i_cfg_wdata;
                pcp_pkg::REG_START_GRACE: r_cfg.grace_ms <= i_cfg_wdata;
                pcp_pkg::REG_DRY_SECONDS: begin
                    r_cfg.dry_lim <= pcp_pkg::DRY_LIM_W'(i_cfg_wdata)
                                     * pcp_pkg::MS_PER_SECOND;
                end
                pcp_pkg::REG_MAX_RUN_HRS: begin
                    r_cfg.flood_lim <= pcp_pkg::FLOOD_LIM_W'(i_cfg_wdata[7:0])
                                       * pcp_pkg::MS_PER_HOUR;
                end
                pcp_pkg::REG_OVL_HOLD:    r_cfg.hold_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/pcp_step.sv */
// ----------------------------------------------------------------------------
// pcp_step: next-state logic for one item
// Start window, overload, dry-run and flood checks for updates, plus the
// start and stop commands. Purely combinational.
// ----------------------------------------------------------------------------
module pcp_step (
    input  pcp_pkg::t_state  i_state,
    input  pcp_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_func,
    input  logic [31:0]      i_now_ms,
    input  logic [15:0]      i_current_ma,
    input  logic             i_web_command,
    output pcp_pkg::t_state  o_state,
    output logic             o_in_grace
);

    logic        over_max;
    logic        under_min;
    logic        in_range;
    logic [31:0] d_grace;
    logic [31:0] d_ovl;
    logic [31:0] d_dry;
    logic [31:0] d_fld;

    assign over_max  = i_current_ma > i_cfg.max_ma;
    assign under_min = i_current_ma < i_cfg.min_ma;
    assign in_range  = !over_max && !under_min;
    assign d_grace   = i_now_ms - i_state.grace_stamp;
    assign d_ovl     = i_now_ms - i_state.ovl_stamp;
    assign d_dry     = i_now_ms - i_state.dry_stamp;
    assign d_fld     = i_now_ms - i_state.fld_stamp;

    always_comb begin
        logic [2:0] st;
        logic       g;
        o_state = i_state;
        g       = 1'b0;
        st      = i_state.status;
        unique case (i_func)
            pcp_pkg::FN_UPDATE: begin
                // start window
                if (!i_state.was_running && i_state.status == pcp_pkg::ST_ON) begin
                    o_state.grace_stamp = i_now_ms;
                    o_state.was_running = 1'b1;
                    g = 1'b1;
                end else if (i_state.was_running && d_grace <= 32'(i_cfg.grace_ms)
                             && i_state.status == pcp_pkg::ST_ON) begin
                    g = 1'b1;
                end
                // overload
                if (!g && st != pcp_pkg::ST_OVERLOAD) begin
                    if (over_max) begin
                        o_state.ovl_armed = 1'b0;
                        if (i_state.ovl_armed) begin
                            o_state.ovl_stamp = i_now_ms;
                        end else if (d_ovl > 32'(i_cfg.hold_ms)) begin
                            st = pcp_pkg::ST_OVERLOAD;
                            o_state.drive = 1'b0;
                        end
                    end else begin
                        o_state.ovl_armed = 1'b1;
                        o_state.ovl_stamp = i_now_ms;
                    end
                end
                // dry run
                if (st != pcp_pkg::ST_DRY) begin
                    if (i_state.dry_armed && under_min && st == pcp_pkg::ST_ON) begin
                        o_state.dry_armed = 1'b0;
                        o_state.dry_stamp = i_now_ms;
                    end else if (!i_state.dry_armed && under_min
                                 && d_dry > 32'(i_cfg.dry_lim) && st == pcp_pkg::ST_ON) begin
                        o_state.dry_stamp = i_now_ms;
                        st = pcp_pkg::ST_DRY;
                        o_state.drive = 1'b0;
                    end else if (!under_min) begin
                        o_state.dry_armed = 1'b1;
                        o_state.dry_stamp = i_now_ms;
                    end
                end
                // flood
                if (st != pcp_pkg::ST_FLOOD) begin
                    if (in_range) begin
                        o_state.fld_armed = 1'b0;
                        if (i_state.fld_armed) begin
                            o_state.fld_stamp = i_now_ms;
                        end else if (d_fld > 32'(i_cfg.flood_lim) && st == pcp_pkg::ST_ON) begin
                            st = pcp_pkg::ST_FLOOD;
                            o_state.drive = 1'b0;
                        end
                    end else begin
                        o_state.fld_armed = 1'b1;
                        o_state.fld_stamp = i_now_ms;
                    end
                end
                o_state.status = st;
            end
            pcp_pkg::FN_START: begin
                if (!i_state.lock) begin
                    o_state.status = pcp_pkg::ST_ON;
                    o_state.drive  = 1'b1;
                end
            end
            pcp_pkg::FN_STOP: begin
                o_state.lock        = i_web_command;
                o_state.dry_armed   = 1'b1;
                o_state.status      = pcp_pkg::ST_OFF;
                o_state.was_running = 1'b0;
                o_state.drive       = 1'b0;
            end
            default: ;
        endcase
        o_in_grace = g;
    end

endmodule

/* tb/sv/pump_current_protection_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_current_protection_unit_test: self-checking bench for the pump unit
// Drives update, start, stop and unused-code items through the input stream,
// predicts status, drive, grace and lockout for each one, and checks every
// output item against the oldest prediction. Runs a directed sequence, then
// randomized start/update/stop sessions under several register settings and
// handshake pacing modes, including a pause until all results are drained.
// ----------------------------------------------------------------------------
module pump_current_protection_unit_test;

    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic       start_locked;
        logic       in_grace;
        logic       drive_on;
        logic [2:0] status;
    } t_pump_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [55:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [pcp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [pcp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;

    pump_current_protection_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predicted protection state and register copy
    logic [2:0]  status_q;
    logic        running_q, drive_q, lock_q;
    logic        ovl_armed_q, dry_armed_q, fld_armed_q;
    logic [31:0] grace_stamp_q, ovl_stamp_q, dry_stamp_q, fld_stamp_q;
    logic [15:0] lim_min_ma, lim_max_ma, grace_ms, dry_s, hold_ms;
    logic [7:0]  run_hrs;

    t_pump_result expected_status_q[$];
    logic [31:0]  clock_ms = 32'd1000;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int trips_seen = 0;
    int mismatches = 0;
    logic [2:0] last_status = pcp_pkg::ST_OFF;

    function automatic void reset_pump_model();
        status_q = pcp_pkg::ST_OFF;
        running_q = 1'b0;
        drive_q = 1'b0;
        lock_q = 1'b0;
        ovl_armed_q = 1'b1;
        dry_armed_q = 1'b1;
        fld_armed_q = 1'b1;
        grace_stamp_q = '0;
        ovl_stamp_q = '0;
        dry_stamp_q = '0;
        fld_stamp_q = '0;
        lim_min_ma = 16'd500;
        lim_max_ma = 16'd10000;
        grace_ms = 16'd3000;
        dry_s = 16'd10;
        run_hrs = 8'd2;
        hold_ms = 16'd500;
    endfunction

    function automatic t_pump_result predict_pump_status(logic [1:0] fn, logic [31:0] now,
                                                         logic [15:0] cur, logic web);
        t_pump_result r;
        logic         grace;
        logic         in_range;
        logic [31:0]  dt;
        logic [63:0]  dry_lim, fld_lim;
        grace = 1'b0;
        dry_lim = 64'(dry_s) * 64'(pcp_pkg::MS_PER_SECOND);
        fld_lim = 64'(run_hrs) * 64'(pcp_pkg::MS_PER_HOUR);
        case (fn)
            pcp_pkg::FN_UPDATE: begin
                // start window
                if (!running_q && status_q == pcp_pkg::ST_ON) begin
                    grace_stamp_q = now;
                    running_q = 1'b1;
                    grace = 1'b1;
                end else begin
                    dt = now - grace_stamp_q;
                    if (running_q && dt <= 32'(grace_ms) && status_q == pcp_pkg::ST_ON)
                        grace = 1'b1;
                end
                // overload, skipped inside the window
                if (!grace && status_q != pcp_pkg::ST_OVERLOAD) begin
                    if (ovl_armed_q && cur > lim_max_ma) begin
                        ovl_armed_q = 1'b0;
                        ovl_stamp_q = now;
                    end
                    dt = now - ovl_stamp_q;
                    if (!ovl_armed_q && cur > lim_max_ma && dt > 32'(hold_ms)) begin
                        status_q = pcp_pkg::ST_OVERLOAD;
                        drive_q = 1'b0;
                    end
                    if (cur <= lim_max_ma) begin
                        ovl_armed_q = 1'b1;
                        ovl_stamp_q = now;
                    end
                end
                // dry run
                if (status_q != pcp_pkg::ST_DRY) begin
                    dt = now - dry_stamp_q;
                    if (dry_armed_q && cur < lim_min_ma && status_q == pcp_pkg::ST_ON) begin
                        dry_armed_q = 1'b0;
                        dry_stamp_q = now;
                    end else if (!dry_armed_q && cur < lim_min_ma && 64'(dt) > dry_lim &&
                                 status_q == pcp_pkg::ST_ON) begin
                        dry_stamp_q = now;
                        status_q = pcp_pkg::ST_DRY;
                        drive_q = 1'b0;
                    end else if (cur >= lim_min_ma) begin
                        dry_armed_q = 1'b1;
                        dry_stamp_q = now;
                    end
                end
                // flood
                in_range = (cur >= lim_min_ma) && (cur <= lim_max_ma);
                if (status_q != pcp_pkg::ST_FLOOD) begin
                    if (fld_armed_q && in_range) begin
                        fld_armed_q = 1'b0;
                        fld_stamp_q = now;
                    end
                    dt = now - fld_stamp_q;
                    if (!fld_armed_q && 64'(dt) > fld_lim && status_q == pcp_pkg::ST_ON
                        && in_range) begin
                        status_q = pcp_pkg::ST_FLOOD;
                        drive_q = 1'b0;
                    end
                    if (!in_range) begin
                        fld_armed_q = 1'b1;
                        fld_stamp_q = now;
                    end
                end
            end
            pcp_pkg::FN_START: begin
                if (!lock_q) begin
                    status_q = pcp_pkg::ST_ON;
                    drive_q = 1'b1;
                end
            end
            pcp_pkg::FN_STOP: begin
                lock_q = web;
                dry_armed_q = 1'b1;
                status_q = pcp_pkg::ST_OFF;
                running_q = 1'b0;
                drive_q = 1'b0;
            end
            default: ;
        endcase
        r.status = status_q;
        r.drive_on = drive_q;
        r.in_grace = grace;
        r.start_locked = lock_q;
        return r;
    endfunction

    task automatic send_item(logic [1:0] fn, logic [31:0] now, logic [15:0] cur, logic web);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {7'd0, web, cur, now};
        s_user <= fn;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_status_q.push_back(predict_pump_status(fn, now, cur, web));
        items_sent++;
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_status_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; caller drops it
    task automatic cfg_write(logic [pcp_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            pcp_pkg::REG_MIN_CURRENT: lim_min_ma = val;
            pcp_pkg::REG_MAX_CURRENT: lim_max_ma = val;
            pcp_pkg::REG_START_GRACE: grace_ms = val;
            pcp_pkg::REG_DRY_SECONDS: dry_s = val;
            pcp_pkg::REG_MAX_RUN_HRS: run_hrs = val[7:0];
            pcp_pkg::REG_OVL_HOLD:    hold_ms = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_pacing(int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
            default: begin src_idle_pct = 25; sink_stall_pct = 25; end
        endcase
    endtask

    // time advance scaled to whichever threshold is in play
    function automatic logic [31:0] pick_step();
        int unsigned hold = hold_ms, win = grace_ms, dry = dry_s, hrs = run_hrs;
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(0, 2 * hold + 2);
            4, 5:       return $urandom_range(0, 2 * win + 2);
            6:          return $urandom_range(0, dry * 2000 + 2);
            7:          return $urandom_range(0, hrs * 7200000 + 2);
            8:          return $urandom;
            default:    return 32'd0;
        endcase
    endfunction

    function automatic logic [15:0] pick_current();
        int unsigned lo = lim_min_ma, hi = lim_max_ma;
        case ($urandom_range(11))
            0, 1, 2:    return (lo == 0) ? 16'd0 : 16'($urandom_range(0, lo - 1));
            3, 4, 5, 6: return (lo <= hi) ? 16'($urandom_range(lo, hi)) : 16'(lo);
            7, 8:       return (hi == 65535) ? 16'hFFFF : 16'($urandom_range(hi + 1, 65535));
            9:          return 16'd0;
            10:         return 16'hFFFF;
            default:    return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // start, a run of updates with the odd stray item, then a stop
    task automatic run_session();
        int n;
        n = $urandom_range(2, 30);
        if ($urandom_range(9) == 0)
            send_item(2'($urandom_range(3)), $urandom, pick_current(), 1'($urandom_range(1)));
        send_item(pcp_pkg::FN_START, clock_ms, pick_current(), 1'($urandom_range(1)));
        repeat (n) begin
            clock_ms += pick_step();
            if ($urandom_range(15) == 0)
                send_item(2'($urandom_range(3)), clock_ms, 16'($urandom_range(0, 65535)),
                          1'($urandom_range(1)));
            else
                send_item(pcp_pkg::FN_UPDATE, clock_ms, pick_current(), 1'($urandom_range(1)));
        end
        send_item(pcp_pkg::FN_STOP, clock_ms, pick_current(), ($urandom_range(3) == 0));
    endtask

    task automatic test_directed_cases();
        logic [31:0] t;
        t = 32'd1000;
        set_pacing(0);
        send_item(FN_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(pcp_pkg::FN_START, t, 16'd0, 1'b0);
        send_item(pcp_pkg::FN_UPDATE, t, 16'd1000, 1'b0);         // opens start window
        send_item(pcp_pkg::FN_UPDATE, t + 100, 16'd20000, 1'b0);  // over-current, in window
        t += 3001;
        send_item(pcp_pkg::FN_UPDATE, t, 16'd20000, 1'b0);        // overload timer starts
        t += 501;
        send_item(pcp_pkg::FN_UPDATE, t, 16'hFFFF, 1'b0);         // overload trip
        send_item(pcp_pkg::FN_START, t, 16'd0, 1'b0);             // restart after fault
        send_item(pcp_pkg::FN_UPDATE, t + 10, 16'd0, 1'b0);       // NaN sample read as 0
        send_item(pcp_pkg::FN_STOP, t, 16'd0, 1'b1);              // web stop locks
        send_item(pcp_pkg::FN_START, t, 16'd0, 1'b0);             // ignored while locked
        send_item(pcp_pkg::FN_UPDATE, t + 20, 16'd1000, 1'b0);
        send_item(pcp_pkg::FN_STOP, t, 16'd0, 1'b0);              // clears lockout
        send_item(pcp_pkg::FN_START, t, 16'd0, 1'b0);
        send_item(pcp_pkg::FN_UPDATE, t, 16'd5000, 1'b0);
        t += 3001;
        send_item(pcp_pkg::FN_UPDATE, t, 16'd100, 1'b0);          // dry timer starts
        t += 10001;
        send_item(pcp_pkg::FN_UPDATE, t, 16'd100, 1'b0);          // dry-run trip
        send_item(pcp_pkg::FN_STOP, t, 16'd0, 1'b0);
        send_item(pcp_pkg::FN_START, t, 16'd0, 1'b0);
        send_item(pcp_pkg::FN_UPDATE, t, 16'd5000, 1'b0);
        t += 3001;
        send_item(pcp_pkg::FN_UPDATE, t, 16'd5000, 1'b0);
        t += 32'd7200001;
        send_item(pcp_pkg::FN_UPDATE, t, 16'd5000, 1'b0);         // flood trip
        send_item(pcp_pkg::FN_UPDATE, t - 5000, 16'hFFFF, 1'b1);  // time going backwards
        send_item(FN_UNUSED, 32'd0, 16'd0, 1'b0);
        send_item(pcp_pkg::FN_STOP, 32'd0, 16'hFFFF, 1'b1);
        clock_ms = t;
        wait_drain();
    endtask

    task automatic test_register_sweep();
        int base;
        for (int p = 0; p < 8; p++) begin
            wait_drain();
            case (p)
                0: ;
                1: for (int r = 0; r < 6; r++) cfg_write(r[2:0], 16'd0);
                2: begin
                    for (int r = 0; r < 6; r++)
                        cfg_write(r[2:0],
                                  (r == pcp_pkg::REG_MAX_RUN_HRS) ? 16'd255 : 16'hFFFF);
                end
                3: begin
                    cfg_write(pcp_pkg::REG_MIN_CURRENT, 16'd500);
                    cfg_write(pcp_pkg::REG_MAX_CURRENT, 16'd10000);
                    cfg_write(pcp_pkg::REG_START_GRACE, 16'd3000);
                    cfg_write(pcp_pkg::REG_DRY_SECONDS, 16'd10);
                    cfg_write(pcp_pkg::REG_MAX_RUN_HRS, 16'd2);
                    cfg_write(pcp_pkg::REG_OVL_HOLD, 16'd500);
                end
                default: begin
                    cfg_write(pcp_pkg::REG_MIN_CURRENT, 16'($urandom_range(0, 3000)));
                    cfg_write(pcp_pkg::REG_MAX_CURRENT, 16'($urandom_range(2000, 40000)));
                    cfg_write(pcp_pkg::REG_START_GRACE, 16'($urandom_range(0, 5000)));
                    cfg_write(pcp_pkg::REG_DRY_SECONDS, 16'($urandom_range(0, 30)));
                    cfg_write(pcp_pkg::REG_MAX_RUN_HRS, 16'($urandom_range(0, 3)));
                    cfg_write(pcp_pkg::REG_OVL_HOLD, 16'($urandom_range(0, 2000)));
                end
            endcase
            cfg_we <= 1'b0;
            set_pacing(p % 4);
            base = items_sent;
            while (items_sent - base < 110) run_session();
        end
    endtask

    // sender holds off until every result is back, then resumes
    task automatic test_drain_pause();
        set_pacing(2);
        repeat (3) begin
            run_session();
            wait_drain();
        end
        set_pacing(3);
        repeat (2) run_session();
    endtask

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_pump_result want;
        t_pump_result got;
        if (i_rst_n && o_m_tvalid && m_ready) begin
            got.status = o_m_tdata[2:0];
            got.drive_on = o_m_tdata[3];
            got.in_grace = o_m_tdata[4];
            got.start_locked = o_m_tdata[5];
            results_seen++;
            if ((got.status == pcp_pkg::ST_DRY || got.status == pcp_pkg::ST_OVERLOAD
                 || got.status == pcp_pkg::ST_FLOOD) && got.status != last_status)
                trips_seen++;
            last_status = got.status;
            if (expected_status_q.size() == 0) begin
                $display("%0t ns: unexpected item, expected none, actual 0x%02h",
                         $time, o_m_tdata);
                mismatches++;
            end else begin
                want = expected_status_q.pop_front();
                report_field("pump_status", want.status, got.status);
                report_field("drive_on", want.drive_on, got.drive_on);
                report_field("in_grace", want.in_grace, got.in_grace);
                report_field("start_locked", want.start_locked, got.start_locked);
            end
        end
    end

    initial begin
        reset_pump_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_register_sweep();
        test_drain_pause();
        wait_drain();
        if (expected_status_q.size() != 0) begin
            $display("%0t ns: %0d items missing, expected 0 pending, actual %0d",
                     $time, expected_status_q.size(), expected_status_q.size());
            mismatches += expected_status_q.size();
        end
        $display("Sent %0d items, checked %0d results, %0d register writes, four pacing modes.",
                 items_sent, results_seen, cfg_writes);
        $display("Saw %0d protection trips (dry run, overload, flood).", trips_seen);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout at %0t ns", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
